[rtl/core/pbge_pkg.sv]
// ----------------------------------------------------------------------------
// Particle burst gravity engine package
// Shared widths, codes, the particle record, the burst direction table and
// the saturating helpers.
// ----------------------------------------------------------------------------
package pbge_pkg;

  // Default sizes
  localparam int CAPACITY_DEF = 512;
  localparam int BURST_DEF    = 16;

  // Field widths
  localparam int OPC_W   = 2;
  localparam int PIX_W   = 11;
  localparam int ENTRY_W = 9;
  localparam int LIVE_W  = 10;
  localparam int POS_W   = 24;
  localparam int VEL_W   = 16;
  localparam int HGT_W   = 11;
  localparam int GRAV_W  = 9;
  localparam int CFG_DW  = 11;
  localparam int CFG_IW  = 1;

  // Opcodes
  localparam logic [OPC_W-1:0] OP_SPAWN = 2'd0;
  localparam logic [OPC_W-1:0] OP_TICK  = 2'd1;
  localparam logic [OPC_W-1:0] OP_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_SCREEN_HEIGHT = 1'd0;
  localparam logic [CFG_IW-1:0] CFG_GRAVITY_STEP  = 1'd1;

  // Register reset values
  localparam logic [HGT_W-1:0]  SCREEN_HEIGHT_RST = 11'd800;
  localparam logic [GRAV_W-1:0] GRAVITY_STEP_RST  = 9'h1F3;  // -13

  // One table entry
  typedef struct packed {
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    logic [VEL_W-1:0] vx;
    logic [VEL_W-1:0] vy;
  } ptcl_t;

  // Burst direction x, whole pixels per tick
  function automatic logic [3:0] dir_x(input logic [3:0] d);
    logic [3:0] v;
    case (d)
      4'd0, 4'd8:   v = 4'sd0;
      4'd1, 4'd7:   v = 4'sd2;
      4'd2, 4'd6:   v = 4'sd4;
      4'd3, 4'd5:   v = 4'sd5;
      4'd4:         v = 4'sd6;
      4'd9, 4'd15:  v = -4'sd2;
      4'd10, 4'd14: v = -4'sd4;
      4'd11, 4'd13: v = -4'sd5;
      default:      v = -4'sd6;
    endcase
    return v;
  endfunction

  // Burst direction y, whole pixels per tick
  function automatic logic [3:0] dir_y(input logic [3:0] d);
    logic [3:0] v;
    case (d)
      4'd0:         v = 4'sd6;
      4'd1, 4'd15:  v = 4'sd5;
      4'd2, 4'd14:  v = 4'sd4;
      4'd3, 4'd13:  v = 4'sd2;
      4'd4, 4'd12:  v = 4'sd0;
      4'd5, 4'd11:  v = -4'sd2;
      4'd6, 4'd10:  v = -4'sd4;
      4'd7, 4'd9:   v = -4'sd5;
      default:      v = -4'sd6;
    endcase
    return v;
  endfunction

  // Whole pixels to 8 fraction bits velocity
  function automatic logic [VEL_W-1:0] pix_to_vel(input logic [3:0] p);
    return {{(VEL_W-12){p[3]}}, p, 8'd0};
  endfunction

  // Clamp a one-bit-grown sum to velocity range
  function automatic logic [VEL_W-1:0] sat_vel(input logic [VEL_W:0] s);
    logic [VEL_W-1:0] r;
    if (s[VEL_W] != s[VEL_W-1]) begin
      r = s[VEL_W] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
    end else begin
      r = s[VEL_W-1:0];
    end
    return r;
  endfunction

  // Clamp a one-bit-grown sum to position range
  function automatic logic [POS_W-1:0] sat_pos(input logic [POS_W:0] s);
    logic [POS_W-1:0] r;
    if (s[POS_W] != s[POS_W-1]) begin
      r = s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      r = s[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/particle_burst_gravity_engine_unit.sv]
// ----------------------------------------------------------------------------
// Particle burst gravity engine
// Keeps a table of live particles in one memory, spawns bursts, advances
// all particles by one gravity tick and reads single entries.
// ----------------------------------------------------------------------------
// One item is handled at a time and gives exactly one result. A spawn
// steps through the burst in ST_SPAWN, writing each entry while the table
// has room. A read of a live slot registers the entry in ST_RD_WAIT; a read
// of any other slot and the unused opcode go straight to ST_FIN. A tick
// reads each particle through the table's registered read port, then runs
// a two-step saturating update (velocity and x first, then y and the
// removal test) and writes each kept entry back. A removed slot is refilled
// with the last live entry, which is updated in the same tick.
// A finished result waits in the output register while the next item is
// accepted. Configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
module particle_burst_gravity_engine_unit #(
  parameter int CAPACITY   = pbge_pkg::CAPACITY_DEF,
  parameter int BURST_SIZE = pbge_pkg::BURST_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // click_x, click_y, entry_index
  input  logic [pbge_pkg::OPC_W-1:0]    in_tuser,   // opcode
  // Result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [63:0]                   out_tdata,  // live_count, entry_x, entry_y
  output logic                          out_tuser,  // entry_valid
  // Configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pbge_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [pbge_pkg::CFG_DW-1:0]   cfg_data
);
  import pbge_pkg::*;

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > ENTRY_W) ? CNT_W : ENTRY_W;
  localparam int BC_W  = ($clog2(BURST_SIZE + 1) > 4) ? $clog2(BURST_SIZE + 1) : 4;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_SPAWN   = 7'b0000010,
    ST_TK_RD   = 7'b0000100,
    ST_TK_LAT  = 7'b0001000,
    ST_TK_UPD  = 7'b0010000,
    ST_RD_WAIT = 7'b0100000,
    ST_FIN     = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [HGT_W-1:0]    scr_h_r;
  logic [GRAV_W-1:0]   grav_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    k_r;
  logic [BC_W-1:0]     burst_r;
  logic [POS_W-1:0]    sp_x_r, sp_y_r;
  ptcl_t               cur_r;
  logic                res_valid_r;
  logic [POS_W-1:0]    res_x_r, res_y_r;
  logic                out_valid_r;
  logic [LIVE_W-1:0]   out_live_r;
  logic                out_ev_r;
  logic [POS_W-1:0]    out_x_r, out_y_r;

  // Unpacked input fields
  logic [OPC_W-1:0]    opcode;
  logic [PIX_W-1:0]    click_x, click_y;
  logic [ENTRY_W-1:0]  entry_index;

  logic                in_xfer, out_free;
  logic                rd_hit;
  logic [CMP_W-1:0]    idx_ext, cnt_ext;
  logic [PIX_W:0]      flip_y;
  logic                spawn_room;
  logic                last_burst;
  logic [VEL_W:0]      vy_sum;
  logic [POS_W:0]      px_sum, py_sum;
  logic [POS_W-1:0]    py_new;
  logic                drop;
  logic                more_after;

  // Table ports
  logic                wr_en, rd_en;
  logic [AW-1:0]       wr_addr, rd_addr;
  ptcl_t               wr_data, rd_data;

  assign opcode      = in_tuser;
  assign click_x     = in_tdata[PIX_W-1:0];
  assign click_y     = in_tdata[2*PIX_W-1:PIX_W];
  assign entry_index = in_tdata[2*PIX_W+ENTRY_W-1:2*PIX_W];

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  // Read slot range test
  assign idx_ext = CMP_W'(entry_index);
  assign cnt_ext = CMP_W'(count_r);
  assign rd_hit  = (idx_ext < cnt_ext);

  // Spawn origin, y flipped against the screen height
  assign flip_y = {1'b0, scr_h_r} - {1'b0, click_y};

  assign spawn_room = (count_r < CNT_W'(CAPACITY));
  assign last_burst = (burst_r == BC_W'(BURST_SIZE - 1));

  // First update step: y velocity and x position
  assign vy_sum = {rd_data.vy[VEL_W-1], rd_data.vy}
                + {{(VEL_W+1-GRAV_W){grav_r[GRAV_W-1]}}, grav_r};
  assign px_sum = {rd_data.px[POS_W-1], rd_data.px}
                + {{(POS_W+1-VEL_W){rd_data.vx[VEL_W-1]}}, rd_data.vx};

  // Second update step: y position and removal test
  assign py_sum = {cur_r.py[POS_W-1], cur_r.py}
                + {{(POS_W+1-VEL_W){cur_r.vy[VEL_W-1]}}, cur_r.vy};
  assign py_new     = sat_pos(py_sum);
  assign drop       = py_new[POS_W-1];
  assign more_after = (k_r < (count_r - CNT_W'(1)));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (opcode)
            OP_SPAWN: state_nxt = ST_SPAWN;
            OP_TICK:  state_nxt = ST_TK_RD;
            OP_READ:  state_nxt = rd_hit ? ST_RD_WAIT : ST_FIN;
            default:  state_nxt = ST_FIN;
          endcase
        end
      end
      ST_SPAWN: begin
        if (last_burst) state_nxt = ST_FIN;
      end
      ST_TK_RD: begin
        state_nxt = (k_r < count_r) ? ST_TK_LAT : ST_FIN;
      end
      ST_TK_LAT: begin
        state_nxt = ST_TK_UPD;
      end
      ST_TK_UPD: begin
        if (!drop)          state_nxt = ST_TK_RD;
        else if (more_after) state_nxt = ST_TK_LAT;
        else                state_nxt = ST_FIN;
      end
      ST_RD_WAIT: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Table access
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = k_r[AW-1:0];
    wr_data = '{px: cur_r.px, py: py_new, vx: cur_r.vx, vy: cur_r.vy};
    rd_en   = 1'b0;
    rd_addr = k_r[AW-1:0];
    if (state_r == ST_SPAWN) begin
      wr_en   = spawn_room;
      wr_addr = count_r[AW-1:0];
      wr_data = '{px: sp_x_r, py: sp_y_r,
                  vx: pix_to_vel(dir_x(burst_r[3:0])),
                  vy: pix_to_vel(dir_y(burst_r[3:0]))};
    end else if (state_r == ST_TK_UPD) begin
      wr_en   = !drop;
      rd_en   = drop && more_after;
      rd_addr = AW'(count_r - CNT_W'(1));
    end else if (state_r == ST_TK_RD) begin
      rd_en   = (k_r < count_r);
    end else if (state_r == ST_IDLE) begin
      rd_en   = in_xfer && (opcode == OP_READ) && rd_hit;
      rd_addr = idx_ext[AW-1:0];
    end
  end

  pbge_table #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      scr_h_r     <= SCREEN_HEIGHT_RST;
      grav_r      <= GRAVITY_STEP_RST;
    end else begin
      state_r <= state_nxt;

      // Register writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SCREEN_HEIGHT: scr_h_r <= cfg_data[HGT_W-1:0];
          CFG_GRAVITY_STEP:  grav_r  <= cfg_data[GRAV_W-1:0];
          default: ;
        endcase
      end

      // Live count: grow on spawn writes, shrink on removals
      if (state_r == ST_SPAWN && spawn_room) begin
        count_r <= count_r + CNT_W'(1);
      end else if (state_r == ST_TK_UPD && drop) begin
        count_r <= count_r - CNT_W'(1);
      end

      // Result register: drop after transfer, load when a result is done
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      k_r         <= '0;
      burst_r     <= '0;
      sp_x_r      <= {{(POS_W-PIX_W-8){1'b0}}, click_x, 8'd0};
      sp_y_r      <= {{(POS_W-PIX_W-9){flip_y[PIX_W]}}, flip_y, 8'd0};
      res_valid_r <= 1'b0;
      res_x_r     <= '0;
      res_y_r     <= '0;
    end
    if (state_r == ST_SPAWN) begin
      burst_r <= burst_r + BC_W'(1);
    end
    if (state_r == ST_TK_LAT) begin
      cur_r.vy <= sat_vel(vy_sum);
      cur_r.px <= sat_pos(px_sum);
      cur_r.py <= rd_data.py;
      cur_r.vx <= rd_data.vx;
    end
    if (state_r == ST_TK_UPD && !drop) begin
      k_r <= k_r + CNT_W'(1);
    end
    if (state_r == ST_RD_WAIT) begin
      res_valid_r <= 1'b1;
      res_x_r     <= rd_data.px;
      res_y_r     <= rd_data.py;
    end
    if (state_r == ST_FIN && out_free) begin
      out_live_r <= LIVE_W'(count_r);
      out_ev_r   <= res_valid_r;
      out_x_r    <= res_x_r;
      out_y_r    <= res_y_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ev_r;
  assign out_tdata  = {{(64-LIVE_W-2*POS_W){1'b0}}, out_y_r, out_x_r, out_live_r};

endmodule

[rtl/core/pbge_table.sv]
// ----------------------------------------------------------------------------
// Particle table memory
// One write port and one registered read port; read data shows one cycle
// after the read is issued.
// ----------------------------------------------------------------------------
module pbge_table #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  pbge_pkg::ptcl_t      wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output pbge_pkg::ptcl_t      rd_data
);
  import pbge_pkg::*;

  ptcl_t mem_r [DEPTH];
  ptcl_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/pbge_checker.sv]
// ----------------------------------------------------------------------------
// Particle burst gravity engine port checker
// Watches the top level's ports for result and handshake consistency.
// ----------------------------------------------------------------------------
module pbge_checker #(
  parameter int CAPACITY = pbge_pkg::CAPACITY_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [63:0]                 out_tdata,
  input logic                        out_tuser
);
  import pbge_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Take one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  // An invalid slot reports zero position
  a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[63:LIVE_W] == '0)
    else $error("nonzero position without a valid slot");

  // Live count never exceeds the table
  a_live_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(out_tdata[LIVE_W-1:0]) <= CAPACITY)
    else $error("live count above capacity");

  // No result right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind particle_burst_gravity_engine_unit pbge_checker #(
  .CAPACITY (CAPACITY)
) u_pbge_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[bench/tb_particle_burst_gravity_engine_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle burst gravity engine testbench
// Drives spawn, tick, read and unused-code items through the input stream
// and predicts every result with a local copy of the particle table. Each
// result is checked field by field against the oldest prediction. Covers a
// full table, saturation, below-window spawns, output back-pressure and
// random traffic under several register settings.
// ----------------------------------------------------------------------------
module tb_particle_burst_gravity_engine_unit;
  import pbge_pkg::*;

  localparam int CAP         = CAPACITY_DEF;
  localparam int BURST       = BURST_DEF;
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

  localparam int POS_HI = 8388607;
  localparam int POS_LO = -8388608;
  localparam int VEL_HI = 32767;
  localparam int VEL_LO = -32768;

  // Burst directions in whole pixels per tick
  localparam int DIR_X [16] = '{0, 2, 4, 5, 6, 5, 4, 2, 0, -2, -4, -5, -6, -5, -4, -2};
  localparam int DIR_Y [16] = '{6, 5, 4, 2, 0, -2, -4, -5, -6, -5, -4, -2, 0, 2, 4, 5};

  typedef struct packed {
    logic [LIVE_W-1:0] live;
    logic              valid;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
  } engine_report_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [31:0]         in_tdata;    // click_x, click_y, entry_index
  logic [OPC_W-1:0]    in_tuser;    // opcode
  logic                out_tvalid;
  logic                out_tready;
  logic [63:0]         out_tdata;   // live_count, entry_x, entry_y
  logic                out_tuser;   // entry_valid
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_IW-1:0]   cfg_index;
  logic [CFG_DW-1:0]   cfg_data;

  // Local copy of the particle table and the registers
  logic signed [POS_W-1:0] tbl_px [CAP];
  logic signed [POS_W-1:0] tbl_py [CAP];
  logic signed [VEL_W-1:0] tbl_vx [CAP];
  logic signed [VEL_W-1:0] tbl_vy [CAP];
  int                      tbl_live;
  int                      tbl_written;   // slots ever written, from 0 up
  logic [HGT_W-1:0]        tbl_height;
  logic signed [GRAV_W-1:0] tbl_grav;

  engine_report_t pending [$];
  int             mismatch_count;
  int unsigned    cycle_count;
  bit             calm;         // no random gaps or stalls on either side while set
  int             sink_hold;    // long output hold-off request, in cycles

  particle_burst_gravity_engine_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Guard against a hung run
  initial begin : watchdog
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic int clamp_to(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the local table by one accepted item and queue its result
  task automatic advance_table(input logic [OPC_W-1:0] op, input logic [PIX_W-1:0] cx,
                               input logic [PIX_W-1:0] cy, input logic [ENTRY_W-1:0] idx);
    engine_report_t rep;
    int k;
    int last;
    int vy;
    int py;
    rep = '0;
    if (op == OP_SPAWN) begin
      py = (int'(tbl_height) - int'(cy)) * 256;
      for (int i = 0; i < BURST; i++) begin
        if (tbl_live < CAP) begin
          tbl_px[tbl_live] = POS_W'(int'(cx) * 256);
          tbl_py[tbl_live] = POS_W'(py);
          tbl_vx[tbl_live] = VEL_W'(DIR_X[i % 16] * 256);
          tbl_vy[tbl_live] = VEL_W'(DIR_Y[i % 16] * 256);
          tbl_live++;
        end
      end
      if (tbl_live > tbl_written) tbl_written = tbl_live;
    end else if (op == OP_TICK) begin
      k = 0;
      while (k < tbl_live) begin
        vy = clamp_to(int'(tbl_vy[k]) + int'(tbl_grav), VEL_LO, VEL_HI);
        tbl_vy[k] = VEL_W'(vy);
        tbl_px[k] = POS_W'(clamp_to(int'(tbl_px[k]) + int'(tbl_vx[k]), POS_LO, POS_HI));
        tbl_py[k] = POS_W'(clamp_to(int'(tbl_py[k]) + vy, POS_LO, POS_HI));
        if (tbl_py[k] < 0) begin
          // move the last live particle in and process it in this tick
          last = tbl_live - 1;
          tbl_px[k] = tbl_px[last];
          tbl_py[k] = tbl_py[last];
          tbl_vx[k] = tbl_vx[last];
          tbl_vy[k] = tbl_vy[last];
          tbl_live  = last;
        end else begin
          k++;
        end
      end
    end else if (op == OP_READ) begin
      if (int'(idx) < tbl_live) begin
        rep.valid = 1'b1;
        rep.x     = tbl_px[idx];
        rep.y     = tbl_py[idx];
      end
    end
    rep.live = LIVE_W'(tbl_live);
    pending.push_back(rep);
  endtask

  // Offer one item after a random gap, none while calm, and hold it until the transfer
  task automatic push_item(input logic [OPC_W-1:0] op, input logic [PIX_W-1:0] cx,
                           input logic [PIX_W-1:0] cy, input logic [ENTRY_W-1:0] idx);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, idx, cy, cx};
    do @(posedge clk); while (!in_tready);
    advance_table(op, cx, cy, idx);
  endtask

  // Drop valid and wait until every result is in
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SCREEN_HEIGHT) tbl_height = data[HGT_W-1:0];
    else tbl_grav = data[GRAV_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(input logic [HGT_W-1:0] h, input logic [GRAV_W-1:0] g);
    wait_idle();
    write_reg(CFG_SCREEN_HEIGHT, CFG_DW'(h));
    write_reg(CFG_GRAVITY_STEP, CFG_DW'(g));
  endtask

  // Pick a slot to read: mostly live ones, else slots written in the past
  task automatic pick_index(output logic [ENTRY_W-1:0] idx, output bit ok);
    ok  = 1'b1;
    idx = '0;
    if (tbl_live > 0 && (tbl_written == tbl_live || $urandom_range(0, 3) != 0)) begin
      idx = ENTRY_W'($urandom_range(0, tbl_live - 1));
    end else if (tbl_written > tbl_live) begin
      idx = ENTRY_W'($urandom_range(tbl_live, tbl_written - 1));
    end else begin
      ok = 1'b0;
    end
  endtask

  task automatic random_item();
    int r;
    logic [OPC_W-1:0]   op;
    logic [PIX_W-1:0]   cx;
    logic [PIX_W-1:0]   cy;
    logic [ENTRY_W-1:0] idx;
    bit ok;
    r   = $urandom_range(0, 99);
    cx  = PIX_W'($urandom);
    cy  = PIX_W'($urandom);
    idx = ENTRY_W'($urandom);
    if (r < 20) begin
      op = OP_SPAWN;
    end else if (r < 50) begin
      op = OP_TICK;
    end else if (r < 95) begin
      op = OP_READ;
      pick_index(idx, ok);
      if (!ok) op = OP_UNUSED;
    end else begin
      op = OP_UNUSED;
    end
    push_item(op, cx, cy, idx);
  endtask

  task automatic read_some_slot();
    logic [ENTRY_W-1:0] idx;
    bit ok;
    pick_index(idx, ok);
    if (ok) push_item(OP_READ, PIX_W'($urandom), PIX_W'($urandom), idx);
  endtask

  // Every opcode, field extremes, below-window spawn, removal
  task automatic test_basic_ops();
    push_item(OP_TICK, 11'd0, 11'd0, 9'd0);
    push_item(OP_UNUSED, 11'd2047, 11'd2047, 9'd511);
    push_item(OP_SPAWN, 11'd0, 11'd0, 9'd511);
    push_item(OP_READ, 11'd2047, 11'd2047, 9'd0);
    push_item(OP_READ, 11'd0, 11'd0, 9'd15);
    // origin below the window bottom
    push_item(OP_SPAWN, 11'd2047, 11'd2047, 9'd0);
    push_item(OP_READ, 11'd0, 11'd0, 9'd16);
    push_item(OP_READ, 11'd0, 11'd0, 9'd31);
    push_item(OP_UNUSED, 11'd0, 11'd0, 9'd0);
    push_item(OP_TICK, 11'd2047, 11'd2047, 9'd511);
    push_item(OP_READ, 11'd0, 11'd0, 9'd16);
    push_item(OP_READ, 11'd0, 11'd0, 9'd31);
    push_item(OP_READ, 11'd0, 11'd0, 9'd2);
    set_regs(11'd2047, 9'd255);
    push_item(OP_SPAWN, 11'd1024, 11'd0, 9'd0);
    push_item(OP_TICK, 11'd0, 11'd0, 9'd0);
    push_item(OP_READ, 11'd0, 11'd0, 9'd16);
    push_item(OP_READ, 11'd0, 11'd0, 9'd31);
    set_regs(11'd1, 9'h100);
    // spawn exactly on the window bottom: y of zero is kept
    push_item(OP_SPAWN, 11'd5, 11'd1, 9'd0);
    push_item(OP_READ, 11'd0, 11'd0, 9'd32);
    push_item(OP_TICK, 11'd0, 11'd0, 9'd0);
    push_item(OP_READ, 11'd0, 11'd0, 9'd0);
    push_item(OP_TICK, 11'd0, 11'd0, 9'd0);
    push_item(OP_READ, 11'd0, 11'd0, 9'd0);
  endtask

  // Fill the table, overflow one burst, then drain it by falling
  task automatic test_table_full();
    set_regs(11'd1, 9'h100);
    while (tbl_live < CAP) push_item(OP_SPAWN, PIX_W'($urandom), 11'd0, 9'd0);
    push_item(OP_SPAWN, 11'd7, 11'd0, 9'd0);
    push_item(OP_READ, 11'd0, 11'd0, 9'd511);
    push_item(OP_READ, 11'd0, 11'd0, 9'd0);
    while (tbl_live > 0) begin
      push_item(OP_TICK, PIX_W'($urandom), PIX_W'($urandom), ENTRY_W'($urandom));
      read_some_slot();
    end
    push_item(OP_READ, 11'd0, 11'd0, 9'd511);
  endtask

  // Strong upward gravity until y velocity and y position saturate
  task automatic test_saturation();
    set_regs(11'd2047, 9'd255);
    push_item(OP_SPAWN, 11'd2047, 11'd0, 9'd0);
    push_item(OP_SPAWN, 11'd0, 11'd0, 9'd0);
    for (int n = 0; n < 310; n++) begin
      push_item(OP_TICK, 11'd0, 11'd0, 9'd0);
      if (n % 10 == 0) read_some_slot();
    end
    for (int i = 0; i < tbl_live; i++) push_item(OP_READ, 11'd0, 11'd0, ENTRY_W'(i));
  endtask

  // Hold the output off for a long stretch while items keep coming
  task automatic test_backpressure();
    set_regs(11'd800, 9'h1F3);
    calm      = 1'b1;
    sink_hold = 600;
    for (int n = 0; n < 40; n++) random_item();
    calm = 1'b0;
  endtask

  task automatic test_random_traffic();
    logic [HGT_W-1:0]  h;
    logic [GRAV_W-1:0] g;
    int p;
    int n;
    for (p = 0; p < 6; p++) begin
      case (p)
        0: begin
          h = 11'd2047;
          g = 9'd255;
        end
        1: begin
          h = 11'd1;
          g = 9'h100;
        end
        2: begin
          h = HGT_W'($urandom_range(1, 2047));
          g = GRAV_W'(-int'($urandom_range(1, 40)));
        end
        3: begin
          h = 11'd800;
          g = 9'h1F3;
        end
        4: begin
          h = HGT_W'($urandom_range(1, 2047));
          g = GRAV_W'($urandom);
        end
        default: begin
          h = HGT_W'($urandom_range(1, 2047));
          g = 9'h100;
        end
      endcase
      set_regs(h, g);
      for (n = 0; n < 112; n++) begin
        if (n % 50 == 0) calm = ($urandom_range(0, 2) == 0);
        random_item();
      end
    end
    calm = 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h actual %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Accept results with random stalls and check each one
  initial begin : result_sink
    engine_report_t got;
    engine_report_t want;
    int stall;
    int hold;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (sink_hold > 0) begin
        hold      = sink_hold;
        sink_hold = 0;
        repeat (hold) begin
          @(negedge clk);
          out_tready <= 1'b0;
        end
      end
      stall = calm ? 0 : $urandom_range(0, 14);
      repeat (stall) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      got.live  = out_tdata[LIVE_W-1:0];
      got.x     = out_tdata[LIVE_W +: POS_W];
      got.y     = out_tdata[LIVE_W+POS_W +: POS_W];
      got.valid = out_tuser;
      if (pending.size() == 0) begin
        $error("result with no pending item: live_count %0d", got.live);
        mismatch_count++;
      end else begin
        want = pending.pop_front();
        compare_field("live_count", 32'(want.live), 32'(got.live));
        compare_field("entry_valid", 32'(want.valid), 32'(got.valid));
        compare_field("entry_x", 32'(want.x), 32'(got.x));
        compare_field("entry_y", 32'(want.y), 32'(got.y));
      end
    end
  end

  initial begin : stimulus
    mismatch_count = 0;
    calm           = 1'b0;
    sink_hold      = 0;
    tbl_live       = 0;
    tbl_written    = 0;
    tbl_height     = SCREEN_HEIGHT_RST;
    tbl_grav       = GRAVITY_STEP_RST;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);

    test_basic_ops();
    test_table_full();
    test_saturation();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
